/* rtl/kdlp_pkg.sv */
`default_nettype none

package kdlp_pkg;

  // default sizes
  localparam int unsigned NumKeysDef   = 3;
  localparam int unsigned TickWidthDef = 32;

  // register port
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgW-1:0] DebounceReset  = 16'd2;
  localparam logic [CfgW-1:0] LongPressReset = 16'd100;

  // result fields
  localparam int unsigned EvtW    = 2;
  localparam int unsigned KeyIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegDebounce  = 1'b0,
    RegLongPress = 1'b1
  } cfg_reg_e;

  typedef enum logic [EvtW-1:0] {
    EvtNone    = 2'd0,
    EvtPress   = 2'd1,
    EvtLong    = 2'd2,
    EvtRelease = 2'd3
  } evt_e;

  // event request of one key slot
  typedef struct packed {
    logic hit;
    evt_e kind;
  } key_evt_t;

endpackage

`default_nettype wire

/* rtl/kdlp_key.sv */
`default_nettype none

module kdlp_key import kdlp_pkg::*; #(
  parameter int unsigned TICK_WIDTH = TickWidthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [TICK_WIDTH-1:0] tick_i,
  input  wire logic                  down_i,
  input  wire logic                  go_i,
  input  wire logic [CfgW-1:0]       debounce_i,
  input  wire logic [CfgW-1:0]       long_press_i,
  output key_evt_t                   evt_o
);

  logic [TICK_WIDTH-1:0] stamp_q, stamp_d;
  logic                  conf_q, conf_d;
  logic                  long_q, long_d;
  logic [TICK_WIDTH-1:0] elapsed;
  logic                  deb_done;
  logic                  long_done;

  // elapsed ticks since first seen down, wraps with the counter
  assign elapsed   = tick_i - stamp_q;
  assign deb_done  = elapsed >= TICK_WIDTH'(debounce_i);
  assign long_done = elapsed >= TICK_WIDTH'(long_press_i);

  // event request and next state of this key
  always_comb begin
    evt_o.hit  = 1'b0;
    evt_o.kind = EvtNone;
    stamp_d    = stamp_q;
    conf_d     = conf_q;
    long_d     = long_q;
    if (down_i && !conf_q) begin
      if (stamp_q == '0) begin
        stamp_d = tick_i;
      end else if (deb_done) begin
        evt_o.hit  = 1'b1;
        evt_o.kind = EvtPress;
        conf_d     = 1'b1;
        long_d     = 1'b0;
      end
    end else if (down_i && !long_q) begin
      if (long_done) begin
        evt_o.hit  = 1'b1;
        evt_o.kind = EvtLong;
        long_d     = 1'b1;
      end
    end else if (!down_i && conf_q) begin
      evt_o.hit  = 1'b1;
      evt_o.kind = EvtRelease;
      conf_d     = 1'b0;
      long_d     = 1'b0;
      stamp_d    = '0;
    end else if (!down_i) begin
      stamp_d = '0;
    end
  end

  // state update only when the scan reaches this key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
      conf_q  <= 1'b0;
      long_q  <= 1'b0;
    end else if (go_i) begin
      stamp_q <= stamp_d;
      conf_q  <= conf_d;
      long_q  <= long_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/key_debounce_long_press_core.sv */
// channel  direction  handshake             payload
// in       to core    in_valid_i/in_stall_o   key_levels_i
// out      from core  out_valid_o/out_stall_i event_kind_o, key_index_o
// cfg      to core    cfg_we_i                cfg_idx_i, cfg_data_i
//
// one scan tick per evaluated transfer: a transfer lands in the input register
// and is evaluated across all keys in parallel with fixed priority once the
// result register is free or draining, loading the result register; one
// result per input transfer; reset clears the tick counter, all key state
// and the result valid flag, and loads the register defaults
// a stalled result holds; the input register still refills as the result moves
`default_nettype none

module key_debounce_long_press_core import kdlp_pkg::*; #(
  parameter int unsigned NUM_KEYS   = NumKeysDef,
  parameter int unsigned TICK_WIDTH = TickWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [NUM_KEYS-1:0] key_levels_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [EvtW-1:0]          event_kind_o,
  output logic [KeyIdxW-1:0]       key_index_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  logic [CfgW-1:0]       debounce_q;
  logic [CfgW-1:0]       long_press_q;
  logic                  in_valid_q;
  logic [NUM_KEYS-1:0]   levels_q;
  logic [TICK_WIDTH-1:0] tick_q;
  logic [TICK_WIDTH-1:0] tick_d;
  logic                  fire;
  key_evt_t              key_evt [NUM_KEYS];
  logic [NUM_KEYS-1:0]   go;
  evt_e                  kind_d;
  logic [KeyIdxW-1:0]    idx_d;
  logic                  out_valid_q;
  evt_e                  kind_q;
  logic [KeyIdxW-1:0]    idx_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegDebounce:  debounce_q   <= cfg_data_i;
        RegLongPress: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // evaluate stage fires when the result register is free or draining
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      levels_q <= key_levels_i;
    end
  end

  // scan tick, advances once per evaluated transfer
  assign tick_d = tick_q + TICK_WIDTH'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (fire) begin
      tick_q <= tick_d;
    end
  end

  // key slots
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kdlp_key #(
      .TICK_WIDTH(TICK_WIDTH)
    ) u_key (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tick_i      (tick_d),
      .down_i      (!levels_q[k]),
      .go_i        (go[k]),
      .debounce_i  (debounce_q),
      .long_press_i(long_press_q),
      .evt_o       (key_evt[k])
    );
  end

  // first event ends the scan, lowest key wins
  always_comb begin
    logic blocked;
    blocked = 1'b0;
    kind_d  = EvtNone;
    idx_d   = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      go[k] = fire && !blocked;
      if (key_evt[k].hit && !blocked) begin
        kind_d = key_evt[k].kind;
        idx_d  = KeyIdxW'(k);
      end
      blocked = blocked | key_evt[k].hit;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q <= kind_d;
      idx_q  <= idx_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign key_index_o  = idx_q;

  // no event carries key zero
  a_none_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_kind_o == EvtNone) |-> key_index_o == '0)
    else $error("event-free result with nonzero key index");

  // tick advances by one per evaluated transfer
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> tick_q == $past(tick_d))
    else $error("tick counter did not advance");

  // tick holds while the input register is empty
  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> $stable(tick_q))
    else $error("tick counter moved without a transfer");

  // a full result register under stall blocks evaluation
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
